/* hdl/p3dcp_pkg.sv */
// Package for the 3D circle point generator: item types, constants, table helpers.
package p3dcp_pkg;

    localparam int POINTS_DEF = 64;
    localparam int GRID_SIZE_DEF = 256;
    localparam logic [6:0] RADIUS_RESET = 7'd16;
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    // One circle description
    typedef struct packed {
        logic [7:0]        center_x;
        logic [7:0]        center_y;
        logic [7:0]        center_z;
        logic signed [7:0] dir_a_x;
        logic signed [7:0] dir_a_y;
        logic signed [7:0] dir_a_z;
        logic signed [7:0] dir_b_x;
        logic signed [7:0] dir_b_y;
        logic signed [7:0] dir_b_z;
        logic [7:0]        color;
    } circle_t;

    // One voxel write
    typedef struct packed {
        logic [7:0] voxel_x;
        logic [7:0] voxel_y;
        logic [7:0] voxel_z;
        logic [7:0] voxel_value;
        logic       in_grid;
        logic       last_point;
    } voxel_t;

    // Normaliser sequencer states
    typedef enum logic [4:0] {
        NS_IDLE = 5'b00001,
        NS_SQRT = 5'b00010,
        NS_PREP = 5'b00100,
        NS_DIV  = 5'b01000,
        NS_DONE = 5'b10000
    } norm_state_t;

    // t * x^2 in Q.30, each product floored
    function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] p;
        p = (t * x) >> 30;
        return (p * x) >> 30;
    endfunction

    // Seven-term sine series in Q.30 (elaboration only)
    function automatic logic [63:0] taylor_sin(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] acc;
        acc = x;
        t = sq_step(x, x) / 64'd6;
        acc = acc - t;
        t = sq_step(t, x) / 64'd20;
        acc = acc + t;
        t = sq_step(t, x) / 64'd42;
        acc = acc - t;
        t = sq_step(t, x) / 64'd72;
        acc = acc + t;
        t = sq_step(t, x) / 64'd110;
        acc = acc - t;
        t = sq_step(t, x) / 64'd156;
        acc = acc + t;
        return acc;
    endfunction

    // Seven-term cosine series in Q.30 (elaboration only)
    function automatic logic [63:0] taylor_cos(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] acc;
        acc = 64'd1 << 30;
        t = sq_step(acc, x) / 64'd2;
        acc = acc - t;
        t = sq_step(t, x) / 64'd12;
        acc = acc + t;
        t = sq_step(t, x) / 64'd30;
        acc = acc - t;
        t = sq_step(t, x) / 64'd56;
        acc = acc + t;
        t = sq_step(t, x) / 64'd90;
        acc = acc - t;
        t = sq_step(t, x) / 64'd132;
        acc = acc + t;
        return acc;
    endfunction

    // Round Q.30 to Q1.14 and cap at one
    function automatic logic signed [15:0] q30_to_q14(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd32768) >> 16;
        if (r > 64'(ONE_Q14))
        begin
            r = 64'(ONE_Q14);
        end
        return 16'(r);
    endfunction

endpackage

/* hdl/parametric_3d_circle_points.sv */
// Top level: 3D circle point generator (normaliser plus point pipeline).
//
//  Channel  | Signals                               | Direction | Moves
//  ---------+---------------------------------------+-----------+---------------------------
//  circle   | circle_valid, circle_stall, circle    | in        | one circle description
//  voxel    | voxel_valid, voxel_stall, voxel       | out       | one voxel write per point
//  radius   | radius_we, radius_wdata               | in        | radius register write
//
// Each circle yields POINTS items, one per cycle while the voxel side does not stall; a new
// circle is taken once the normaliser is free. The normaliser runs 23 square root steps,
// one set-up step and 16 divide steps, one bit each, and then hands over to the sequencer.
// The next circle is normalised while the current one is still being emitted.
// The point pipeline has register stages for table read, direction products, radius
// scaling and output. Reset clears all valid bits and sets the radius to 16.
// A stall on the voxel side freezes the whole point pipeline; nothing is lost.
module parametric_3d_circle_points #(
    parameter int POINTS = p3dcp_pkg::POINTS_DEF,
    parameter int GRID_SIZE = p3dcp_pkg::GRID_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                circle_valid,
    output logic                circle_stall,
    input  p3dcp_pkg::circle_t  circle,
    output logic                voxel_valid,
    input  logic                voxel_stall,
    output p3dcp_pkg::voxel_t   voxel,
    input  logic                radius_we,
    input  logic [6:0]          radius_wdata
);
    import p3dcp_pkg::*;

    localparam int KW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(POINTS - 1);
    localparam logic [11:0] GRID_MAX = 12'(GRID_SIZE - 1);
    localparam logic [7:0] GRID_MAX8 = 8'(GRID_SIZE - 1);
    localparam logic signed [39:0] MINUS_ONE_Q28 = -40'sd268435456;

    // ---------------------------------------------------------------
    // Cosine / sine table, built at elaboration
    // ---------------------------------------------------------------
    logic signed [15:0] sin_tab [POINTS];
    logic signed [15:0] cos_tab [POINTS];

    for (genvar g = 0; g < POINTS; g++)
    begin : g_tab
        localparam int V = 4 * g;
        localparam int QUAD = (V / POINTS) % 4;
        localparam int REM = V % POINTS;
        localparam bit SWAP = (2 * REM > POINTS);
        localparam int F = SWAP ? (POINTS - REM) : REM;
        localparam logic [63:0] X = (64'(F) * PI_Q30 + 64'(POINTS)) / 64'(2 * POINTS);
        localparam logic signed [15:0] S0R = q30_to_q14(taylor_sin(X));
        localparam logic signed [15:0] C0R = q30_to_q14(taylor_cos(X));
        localparam logic signed [15:0] S0 = SWAP ? C0R : S0R;
        localparam logic signed [15:0] C0 = SWAP ? S0R : C0R;
        assign sin_tab[g] = (QUAD == 0) ? S0 : (QUAD == 1) ? C0 : (QUAD == 2) ? -S0 : -C0;
        assign cos_tab[g] = (QUAD == 0) ? C0 : (QUAD == 1) ? -S0 : (QUAD == 2) ? -C0 : S0;
    end

    // ---------------------------------------------------------------
    // Radius register
    // ---------------------------------------------------------------
    logic [6:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (radius_we)
        begin
            radius_reg <= radius_wdata;
        end
    end

    // ---------------------------------------------------------------
    // Normaliser: integer square root, then per-component divide
    // ---------------------------------------------------------------
    norm_state_t norm_state_reg, norm_state_next;
    logic [4:0]  step_cnt_reg, step_cnt_next;

    logic [7:0]  mag_reg   [2][3];
    logic        neg_reg   [2][3];
    logic [44:0] sq_n_reg  [2];
    logic [44:0] sq_res_reg[2];
    logic [44:0] sq_bit_reg;
    logic [22:0] rem_reg   [2][3];
    logic [15:0] quo_reg   [2][3];
    logic        cap_reg   [2][3];
    logic        zr_reg    [2];
    logic [7:0]  cen_reg   [3];
    logic [7:0]  color_reg;

    logic signed [7:0]  dir_in  [2][3];
    logic [7:0]         mag_in  [2][3];
    logic [16:0]        ssq_in  [2];
    logic [45:0]        trial   [2];
    logic               take    [2];
    logic [22:0]        root    [2];
    logic [23:0]        rem_sh  [2][3];
    logic               ge      [2][3];
    logic [15:0]        qv      [2][3];
    logic signed [15:0] unit    [2][3];

    logic circle_take;
    logic seq_load;

    assign circle_stall = (norm_state_reg != NS_IDLE);
    assign circle_take  = circle_valid && !circle_stall;

    // Input unpacking, magnitudes and squared lengths
    always_comb
    begin
        dir_in[0][0] = circle.dir_a_x;
        dir_in[0][1] = circle.dir_a_y;
        dir_in[0][2] = circle.dir_a_z;
        dir_in[1][0] = circle.dir_b_x;
        dir_in[1][1] = circle.dir_b_y;
        dir_in[1][2] = circle.dir_b_z;
        for (int v = 0; v < 2; v++)
        begin
            ssq_in[v] = '0;
            for (int i = 0; i < 3; i++)
            begin
                mag_in[v][i] = dir_in[v][i][7] ? 8'(~dir_in[v][i] + 8'd1) : 8'(dir_in[v][i]);
                ssq_in[v] = ssq_in[v] + 17'(mag_in[v][i]) * 17'(mag_in[v][i]);
            end
        end
    end

    // One root step and one quotient bit per lane
    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            trial[v] = 46'(sq_res_reg[v]) + 46'(sq_bit_reg);
            take[v]  = 46'(sq_n_reg[v]) >= trial[v];
            root[v]  = sq_res_reg[v][22:0];
            for (int i = 0; i < 3; i++)
            begin
                rem_sh[v][i] = {rem_reg[v][i], 1'b0};
                ge[v][i]     = rem_sh[v][i] >= {1'b0, root[v]};
                if (zr_reg[v])
                begin
                    qv[v][i] = '0;
                end
                else if (cap_reg[v][i] || quo_reg[v][i] > ONE_Q14)
                begin
                    qv[v][i] = ONE_Q14;
                end
                else
                begin
                    qv[v][i] = quo_reg[v][i];
                end
                unit[v][i] = neg_reg[v][i] ? (16'd0 - qv[v][i]) : qv[v][i];
            end
        end
    end

    // Normaliser sequencing
    always_comb
    begin
        norm_state_next = norm_state_reg;
        step_cnt_next   = step_cnt_reg;
        case (norm_state_reg)
            NS_IDLE:
            begin
                if (circle_valid)
                begin
                    norm_state_next = NS_SQRT;
                    step_cnt_next   = 5'd22;
                end
            end
            NS_SQRT:
            begin
                step_cnt_next = step_cnt_reg - 5'd1;
                if (step_cnt_reg == '0)
                begin
                    norm_state_next = NS_PREP;
                end
            end
            NS_PREP:
            begin
                norm_state_next = NS_DIV;
                step_cnt_next   = 5'd15;
            end
            NS_DIV:
            begin
                step_cnt_next = step_cnt_reg - 5'd1;
                if (step_cnt_reg == '0)
                begin
                    norm_state_next = NS_DONE;
                end
            end
            NS_DONE:
            begin
                if (seq_load)
                begin
                    norm_state_next = NS_IDLE;
                end
            end
            default:
            begin
                norm_state_next = NS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_state_reg <= NS_IDLE;
            step_cnt_reg   <= '0;
        end
        else
        begin
            norm_state_reg <= norm_state_next;
            step_cnt_reg   <= step_cnt_next;
        end
    end

    // Normaliser datapath
    always_ff @(posedge clk)
    begin
        if (circle_take)
        begin
            cen_reg[0] <= circle.center_x;
            cen_reg[1] <= circle.center_y;
            cen_reg[2] <= circle.center_z;
            color_reg  <= circle.color;
            sq_bit_reg <= 45'd1 << 44;
            for (int v = 0; v < 2; v++)
            begin
                sq_n_reg[v]   <= {ssq_in[v], 28'd0};
                sq_res_reg[v] <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[v][i] <= mag_in[v][i];
                    neg_reg[v][i] <= dir_in[v][i][7];
                end
            end
        end
        else if (norm_state_reg == NS_SQRT)
        begin
            sq_bit_reg <= sq_bit_reg >> 2;
            for (int v = 0; v < 2; v++)
            begin
                if (take[v])
                begin
                    sq_n_reg[v]   <= sq_n_reg[v] - trial[v][44:0];
                    sq_res_reg[v] <= (sq_res_reg[v] >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg[v] <= sq_res_reg[v] >> 1;
                end
            end
        end
        else if (norm_state_reg == NS_PREP)
        begin
            for (int v = 0; v < 2; v++)
            begin
                zr_reg[v] <= (root[v] == '0);
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[v][i] <= {3'd0, mag_reg[v][i], 12'd0};
                    cap_reg[v][i] <= {3'd0, mag_reg[v][i], 12'd0} >= root[v];
                    quo_reg[v][i] <= '0;
                end
            end
        end
        else if (norm_state_reg == NS_DIV)
        begin
            for (int v = 0; v < 2; v++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (ge[v][i])
                    begin
                        rem_reg[v][i] <= 23'(rem_sh[v][i] - {1'b0, root[v]});
                    end
                    else
                    begin
                        rem_reg[v][i] <= rem_sh[v][i][22:0];
                    end
                    quo_reg[v][i] <= {quo_reg[v][i][14:0], ge[v][i]};
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Point sequencer
    // ---------------------------------------------------------------
    logic               seq_active_reg;
    logic [KW-1:0]      k_reg;
    logic signed [15:0] ua_reg [3];
    logic signed [15:0] ub_reg [3];
    logic [7:0]         seq_cen_reg [3];
    logic [7:0]         seq_color_reg;
    logic               advance;
    logic               seq_issue;
    logic               seq_last;
    logic [KW-1:0]      angle_idx;
    logic               voxel_valid_reg;

    assign advance   = !voxel_valid_reg || !voxel_stall;
    assign seq_issue = seq_active_reg && advance;
    assign seq_last  = (k_reg == K_LAST);
    assign seq_load  = (norm_state_reg == NS_DONE) && (!seq_active_reg || (seq_issue && seq_last));
    assign angle_idx = K_LAST - k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
            k_reg          <= '0;
        end
        else if (seq_load)
        begin
            seq_active_reg <= 1'b1;
            k_reg          <= '0;
        end
        else if (seq_issue)
        begin
            if (seq_last)
            begin
                seq_active_reg <= 1'b0;
                k_reg          <= '0;
            end
            else
            begin
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_load)
        begin
            seq_color_reg <= color_reg;
            for (int i = 0; i < 3; i++)
            begin
                ua_reg[i]      <= unit[0][i];
                ub_reg[i]      <= unit[1][i];
                seq_cen_reg[i] <= cen_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Point pipeline
    // ---------------------------------------------------------------
    // stage 1: table read
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic signed [15:0] s1_cs_reg, s1_sn_reg;
    logic signed [15:0] s1_ua_reg [3];
    logic signed [15:0] s1_ub_reg [3];
    logic [7:0]         s1_cen_reg [3];
    logic [7:0]         s1_color_reg;
    // stage 2: direction products
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic signed [31:0] s2_pa_reg [3];
    logic signed [31:0] s2_pb_reg [3];
    logic [7:0]         s2_cen_reg [3];
    logic [7:0]         s2_color_reg;
    // stage 3: radius scaling
    logic               s3_valid_reg;
    logic               s3_last_reg;
    logic signed [39:0] s3_prod_reg [3];
    logic [7:0]         s3_cen_reg [3];
    logic [7:0]         s3_color_reg;
    // stage 4: output register
    voxel_t             voxel_reg, voxel_next;

    logic signed [31:0] s2_sum   [3];
    logic signed [39:0] sum_ext  [3];
    logic signed [39:0] rad_ext;
    logic signed [39:0] tot      [3];
    logic [7:0]         coord    [3];
    logic               in_rng   [3];

    always_comb
    begin
        rad_ext = {33'd0, radius_reg};
        for (int i = 0; i < 3; i++)
        begin
            s2_sum[i]  = s2_pa_reg[i] + s2_pb_reg[i];
            sum_ext[i] = 40'(s2_sum[i]);
        end
    end

    // Truncate toward zero and saturate to the grid
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tot[i] = s3_prod_reg[i] + $signed({4'd0, s3_cen_reg[i], 28'd0});
            if (tot[i][39])
            begin
                coord[i]  = '0;
                in_rng[i] = !(tot[i] <= MINUS_ONE_Q28);
            end
            else if (tot[i][39:28] > GRID_MAX)
            begin
                coord[i]  = GRID_MAX8;
                in_rng[i] = 1'b0;
            end
            else
            begin
                coord[i]  = tot[i][35:28];
                in_rng[i] = 1'b1;
            end
        end
        voxel_next.voxel_x     = coord[0];
        voxel_next.voxel_y     = coord[1];
        voxel_next.voxel_z     = coord[2];
        voxel_next.voxel_value = s3_color_reg;
        voxel_next.in_grid     = in_rng[0] && in_rng[1] && in_rng[2];
        voxel_next.last_point  = s3_last_reg;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            voxel_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg    <= seq_active_reg;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            voxel_valid_reg <= s3_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_cs_reg    <= cos_tab[angle_idx];
            s1_sn_reg    <= sin_tab[angle_idx];
            s1_last_reg  <= seq_last;
            s1_color_reg <= seq_color_reg;
            s2_last_reg  <= s1_last_reg;
            s2_color_reg <= s1_color_reg;
            s3_last_reg  <= s2_last_reg;
            s3_color_reg <= s2_color_reg;
            voxel_reg    <= voxel_next;
            for (int i = 0; i < 3; i++)
            begin
                s1_ua_reg[i]   <= ua_reg[i];
                s1_ub_reg[i]   <= ub_reg[i];
                s1_cen_reg[i]  <= seq_cen_reg[i];
                s2_pa_reg[i]   <= s1_cs_reg * s1_ua_reg[i];
                s2_pb_reg[i]   <= s1_sn_reg * s1_ub_reg[i];
                s2_cen_reg[i]  <= s1_cen_reg[i];
                s3_prod_reg[i] <= sum_ext[i] * rad_ext;
                s3_cen_reg[i]  <= s2_cen_reg[i];
            end
        end
    end

    assign voxel_valid = voxel_valid_reg;
    assign voxel       = voxel_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_unit_capped: assert property (@(posedge clk) disable iff (!rst_n)
        (norm_state_reg == NS_DONE) |->
            (qv[0][0] <= ONE_Q14 && qv[0][1] <= ONE_Q14 && qv[0][2] <= ONE_Q14 &&
             qv[1][0] <= ONE_Q14 && qv[1][1] <= ONE_Q14 && qv[1][2] <= ONE_Q14))
        else $error("unit vector component above one");

    a_last_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_issue && seq_last) |=> (s1_valid_reg && s1_last_reg))
        else $error("final point lost entering the pipeline");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_active_reg |-> (k_reg == '0))
        else $error("point counter not cleared while idle");

    a_outside_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (voxel_valid && !voxel.in_grid) |->
            (voxel.voxel_x == '0 || voxel.voxel_x == GRID_MAX8 ||
             voxel.voxel_y == '0 || voxel.voxel_y == GRID_MAX8 ||
             voxel.voxel_z == '0 || voxel.voxel_z == GRID_MAX8))
        else $error("outside point without a saturated coordinate");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        seq_load |=> (seq_active_reg && k_reg == '0 && norm_state_reg == NS_IDLE))
        else $error("circle handover to the sequencer went wrong");

endmodule
